FILE: sv/olie_pkg.sv
// Shared types and constants for the ordered list insert/erase core.
package olie_pkg;

  localparam int CapacityDefault = 64;
  localparam int OpcodeW         = 3;
  localparam int PositionW       = 6;
  localparam int WordW           = 32;
  localparam int EntryCountW     = 7;
  localparam int StatusW         = 2;

  typedef enum logic [OpcodeW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ERASE  = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Update that every cell of the chain sees in the same cycle.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_INSERT,
    ACT_ERASE,
    ACT_WRITE
  } act_t;

  typedef struct packed {
    act_t                    act;
    logic signed [WordW-1:0] word;
  } cell_ctl_t;

  typedef struct packed {
    logic [OpcodeW-1:0]      opcode;
    logic [PositionW-1:0]    position;
    logic signed [WordW-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] read_word;
    logic [EntryCountW-1:0]  entry_count;
    logic [StatusW-1:0]      status;
  } out_item_t;

endpackage

FILE: sv/olie_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
module olie_cell import olie_pkg::*; #(
  parameter int INDEX = 0,
  parameter int PW    = 7
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic [PW-1:0]           pos,
  input  logic [PW-1:0]           count,
  input  logic signed [WordW-1:0] left_value,
  input  logic signed [WordW-1:0] right_value,
  output logic signed [WordW-1:0] value
);

  localparam logic [PW-1:0] MyIndex = PW'(INDEX);

  logic signed [WordW-1:0] value_next;
  logic                    at_pos;
  logic                    above_pos;

  assign at_pos    = (MyIndex == pos);
  assign above_pos = (MyIndex > pos);

  always_comb begin
    value_next = value;
    unique case (ctl.act)
      ACT_APPEND: begin
        if (MyIndex == count) value_next = ctl.word;
      end
      ACT_INSERT: begin
        if (at_pos) value_next = ctl.word;
        else if (above_pos) value_next = left_value;
      end
      ACT_ERASE: begin
        if (at_pos || above_pos) value_next = right_value;
      end
      ACT_WRITE: begin
        if (at_pos) value_next = ctl.word;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: sv/ordered_list_insert_erase_core.sv
// Ordered list of signed words: append, insert, erase, read and write.
//
// Usage: one item on in_item per transfer (valid/ready); one result per item
// on out_item. Each result carries the read word (zero unless a read hit),
// the entry count after the operation and a status code.
// The result of an item accepted at one edge is registered and shown on
// out_item after that edge. The block takes one item per cycle while the
// receiver takes results; insert and erase never hold the flow, as each
// entry sits in its own cell and all cells shift to their neighbors at once.
// A read selects one cell through a CAPACITY-to-one multiplexer.
// The output register parts the two sides: a new item is taken while the
// previous result is being transferred, and when the receiver stalls the
// block holds its result and drops in_ready until the result is taken.
// Reset empties the list (count zero) and clears out_valid; entry contents
// are not cleared and are only read after they have been written.
module ordered_list_insert_erase_core import olie_pkg::*; #(
  parameter int CAPACITY = CapacityDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = (CNT_W > PositionW) ? CNT_W : PositionW;
  localparam logic [CNT_W-1:0] CountFull = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic signed [WordW-1:0] values [CAPACITY];
  logic                    accept;
  logic [PW-1:0]           pos_w;
  logic [PW-1:0]           cnt_w;
  logic [IDX_W-1:0]        pos_idx;
  logic                    pos_ok;
  logic                    full;
  act_t                    act;
  status_t                 status;
  logic signed [WordW-1:0] rd_word;
  cell_ctl_t               ctl;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_w   = PW'(in_item.position);
  assign cnt_w   = PW'(count);
  assign pos_idx = IDX_W'(pos_w);
  assign pos_ok  = (pos_w < cnt_w);
  assign full    = (count == CountFull);

  always_comb begin
    act        = ACT_NONE;
    status     = ST_DONE;
    rd_word    = '0;
    count_next = count;
    unique case (op_t'(in_item.opcode))
      OP_APPEND: begin
        if (full) status = ST_FULL;
        else begin
          act        = ACT_APPEND;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (!pos_ok) status = ST_RANGE;
        else if (full) status = ST_FULL;
        else begin
          act        = ACT_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (!pos_ok) status = ST_RANGE;
        else begin
          act        = ACT_ERASE;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok) status = ST_RANGE;
        else rd_word = values[pos_idx];
      end
      OP_WRITE: begin
        if (!pos_ok) status = ST_RANGE;
        else act = ACT_WRITE;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  assign ctl.act  = accept ? act : ACT_NONE;
  assign ctl.word = in_item.data_word;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
    localparam int RIGHT = (gi == CAPACITY - 1) ? gi : gi + 1;

    olie_cell #(
      .INDEX (gi),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pos         (pos_w),
      .count       (cnt_w),
      .left_value  (values[LEFT]),
      .right_value (values[RIGHT]),
      .value       (values[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.read_word   <= rd_word;
      out_item.entry_count <= EntryCountW'(count_next);
      out_item.status      <= status;
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the ordered list insert/erase core.
module tb_top;
  import olie_pkg::*;

  localparam int ListCap      = CapacityDefault;
  localparam int RandomItems  = 1700;
  localparam int SegmentItems = 120;
  localparam int IdleLimit    = 2000;
  localparam int HoldCycles   = 200;
  localparam int HoldSpacing  = 700;
  localparam int DrainCycles  = 8;

  // Generator modes: grow the list, shrink it, or mix everything.
  localparam int ModeGrow   = 0;
  localparam int ModeShrink = 1;
  localparam int ModeMixed  = 2;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  ordered_list_insert_erase_core #(
    .CAPACITY(ListCap)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];

  // Shadow of the list as the block should hold it.
  logic signed [WordW-1:0] list_words[ListCap];
  int list_len = 0;

  // Length the list will have once every queued operation is done.
  int plan_len = 0;

  int total_items    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int full_hits      = 0;
  int range_hits     = 0;
  int shifted_ops    = 0;
  int peak_len       = 0;

  logic in_fire = 1'b0;

  // Computes the result of one operation and updates the shadow list.
  function automatic out_item_t list_apply(in_item_t it);
    out_item_t res;
    int p;
    int i;
    p = it.position;
    res.read_word = '0;
    res.status = ST_DONE;
    case (it.opcode)
      OP_APPEND: begin
        if (list_len >= ListCap) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = it.data_word;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= ListCap) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = it.data_word;
          list_len++;
          shifted_ops++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          shifted_ops++;
        end
      end
      OP_READ: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_word = list_words[p];
      end
      OP_WRITE: begin
        if (p >= list_len) res.status = ST_RANGE;
        else list_words[p] = it.data_word;
      end
      default: begin
      end
    endcase
    res.entry_count = list_len[EntryCountW-1:0];
    if (res.status == ST_FULL) full_hits++;
    if (res.status == ST_RANGE) range_hits++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // Queues one operation and tracks the list length it leads to.
  function automatic void plan_op(logic [OpcodeW-1:0] op, int pos, logic [WordW-1:0] word);
    in_item_t it;
    it.opcode = op;
    it.position = pos[PositionW-1:0];
    it.data_word = word;
    pending_ops.insert(pending_ops.size(), it);
    total_items++;
    case (op)
      OP_APPEND: if (plan_len < ListCap) plan_len++;
      OP_INSERT: if (pos < plan_len && plan_len < ListCap) plan_len++;
      OP_ERASE:  if (pos < plan_len) plan_len--;
      default: begin
      end
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'h7fff_ffff;
    if (r < 8) return 32'h8000_0000;
    if (r < 11) return 32'hffff_ffff;
    if (r < 14) return 32'h0;
    return $urandom;
  endfunction

  function automatic void plan_random(int mode);
    logic [OpcodeW-1:0] op;
    int r;
    int pos;
    bit noise;
    r = $urandom_range(0, 99);
    noise = ($urandom_range(0, 99) < 8);
    case (mode)
      ModeGrow: begin
        if (r < 45) op = OP_APPEND;
        else if (r < 80) op = OP_INSERT;
        else if (r < 88) op = OP_READ;
        else if (r < 95) op = OP_WRITE;
        else op = OP_ERASE;
      end
      ModeShrink: begin
        if (r < 55) op = OP_ERASE;
        else if (r < 70) op = OP_READ;
        else if (r < 85) op = OP_WRITE;
        else if (r < 95) op = OP_APPEND;
        else op = OP_INSERT;
      end
      default: begin
        if (r < 20) op = OP_APPEND;
        else if (r < 40) op = OP_INSERT;
        else if (r < 60) op = OP_ERASE;
        else if (r < 80) op = OP_READ;
        else op = OP_WRITE;
      end
    endcase
    if (noise && $urandom_range(0, 3) == 0) op = 3'($urandom_range(5, 7));
    if (noise || plan_len == 0) begin
      // Mostly positions at or past the end of the list.
      if (plan_len < ListCap) pos = $urandom_range(plan_len, ListCap - 1);
      else pos = $urandom_range(0, ListCap - 1);
    end else begin
      r = $urandom_range(0, 9);
      if (r == 0) pos = 0;
      else if (r == 1) pos = plan_len - 1;
      else pos = $urandom_range(0, plan_len - 1);
    end
    plan_op(op, pos, pick_word());
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Sender: capture transfers at the rising edge, present items at the falling edge.
  int tx_gap   = 0;
  int tx_phase = 0;
  bit tx_calm  = 1'b0;

  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_results.insert(expected_results.size(), list_apply(in_item));
      items_accepted++;
    end
  end

  always @(negedge clk) begin
    if (tx_phase == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_phase = 250;
    end else begin
      tx_phase--;
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_ops.size() != 0) begin
        in_item <= pending_ops.pop_front();
        in_valid <= 1'b1;
        if (tx_calm || $urandom_range(0, 99) < 70) tx_gap = 0;
        else tx_gap = pick_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check results at the rising edge, move ready at the falling edge.
  int rx_stall  = 0;
  int rx_hold   = 0;
  int rx_phase  = 0;
  int hold_mark = 400;
  bit rx_calm   = 1'b0;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: word %0d count %0d status %0d", $realtime,
                 out_item.read_word, out_item.entry_count, out_item.status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.read_word !== want.read_word ||
            out_item.entry_count !== want.entry_count ||
            out_item.status !== want.status) begin
          $display("%0t: mismatch: expected word %0d count %0d status %0d,",
                   $realtime, want.read_word, want.entry_count, want.status,
                   " got word %0d count %0d status %0d",
                   out_item.read_word, out_item.entry_count, out_item.status);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_calm = ($urandom_range(0, 3) == 0);
      rx_phase = 300;
    end else begin
      rx_phase--;
    end
    // Long hold-off so the block fills up and stalls its input.
    if (results_seen >= hold_mark) begin
      rx_hold = HoldCycles;
      hold_mark += HoldSpacing;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      out_ready <= 1'b0;
      rx_stall = pick_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $realtime,
                 idle_cycles, expected_results.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int mode;
    // Directed part: empty list, word extremes, insert at the end, ignored opcodes.
    plan_op(OP_READ, 0, 32'h1);
    plan_op(OP_ERASE, 0, 32'h0);
    plan_op(OP_WRITE, 0, 32'h5);
    plan_op(OP_INSERT, 0, 32'h9);
    plan_op(OP_APPEND, 0, 32'h7fff_ffff);
    plan_op(OP_APPEND, 63, 32'h8000_0000);
    plan_op(OP_INSERT, 0, 32'hffff_ffff);
    plan_op(OP_INSERT, 3, 32'h1234_5678);
    plan_op(OP_INSERT, 63, 32'h1);
    plan_op(OP_READ, 0, 32'h0);
    plan_op(OP_READ, 1, 32'h0);
    plan_op(OP_READ, 2, 32'hffff_ffff);
    plan_op(OP_WRITE, 2, 32'h0);
    plan_op(OP_READ, 2, 32'h0);
    plan_op(OP_ERASE, 1, 32'h0);
    plan_op(OP_READ, 1, 32'h0);
    plan_op(OP_READ, 63, 32'h0);
    plan_op(OP_ERASE, 2, 32'h0);
    plan_op(3'd5, 63, 32'hffff_ffff);
    plan_op(3'd6, 0, 32'h0);
    plan_op(3'd7, 1, 32'h8000_0000);
    plan_op(OP_ERASE, 0, 32'h0);
    plan_op(OP_ERASE, 0, 32'h0);
    plan_op(OP_APPEND, 0, 32'h0);
    // Random part in segments that grow the list to full, mix, and drain it.
    for (n = 0; n < RandomItems; n++) begin
      case ((n / SegmentItems) % 4)
        0: mode = ModeGrow;
        2: mode = ModeShrink;
        default: mode = ModeMixed;
      endcase
      plan_random(mode);
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < total_items) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Ran %0d operations with %0d results: %0d shifting inserts/erases,",
             items_accepted, results_seen, shifted_ops);
    $display("%0d full and %0d out-of-range rejects, peak length %0d.",
             full_hits, range_hits, peak_len);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
